// File: hw/rtl/square_wave_sound_generator_core_macros.svh
// assertion macros for the square wave sound generator core
// used by modules that assert; expects clk and rst_n in scope
`ifndef SQUARE_WAVE_SOUND_GENERATOR_CORE_MACROS_SVH
`define SQUARE_WAVE_SOUND_GENERATOR_CORE_MACROS_SVH

// same-cycle implication
`define SQW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SQW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sqw_pkg.sv
// types, constants and helpers for the square wave sound generator
// no dependencies
package sqw_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_TICK  = 2'd2
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_RFRD,
    S_VRD,
    S_DIV,
    S_TRD,
    S_TWR,
    S_NOISE,
    S_DONE
  } state_t;

  // one voice entry of the voice memory
  typedef struct packed {
    logic [10:0] pitch;
    logic [12:0] step;
    logic [14:0] phase;
    logic        level;
    logic [7:0]  vol;
  } voice_t;

  // request to the step divider
  typedef struct packed {
    logic        start;
    logic [20:0] num;
    logic [8:0]  den;
  } div_req_t;

  localparam logic [15:0] PHASE_MOD  = 16'd22050;
  localparam logic [6:0]  MIX_SCALE  = 7'd90;
  localparam logic [20:0] TONE_BASE  = 21'd15625;
  localparam logic [8:0]  NOTE_BASE  = 9'd511;
  localparam logic [15:0] RATE_FAST  = 16'd31250;
  localparam logic [15:0] RATE_MID   = 16'd15625;
  localparam logic [15:0] RATE_SLOW  = 16'd7812;
  localparam logic [4:0]  REG_TONE_EN  = 5'h14;
  localparam logic [4:0]  REG_NOISE_EN = 5'h15;
  localparam logic [4:0]  REG_NOISE_MD = 5'h16;
  localparam logic [4:0]  REG_GLOBAL   = 5'h1C;
  localparam logic [4:0]  REG_VOL_LAST = 5'h05;
  localparam logic [4:0]  REG_NOTE_LO  = 5'h08;
  localparam logic [4:0]  REG_NOTE_HI  = 5'h0D;
  localparam logic [4:0]  REG_OCT_LO   = 5'h10;
  localparam logic [4:0]  REG_OCT_HI   = 5'h12;

  // one noise shift: feed a one when bits 14 and 6 agree after the shift
  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] n;
    n = {s[14:0], 1'b0};
    if (n[14] == n[6]) n[0] = 1'b1;
    return n;
  endfunction

endpackage

// File: hw/rtl/sqw_div.sv
// restoring divider for the tone step, one quotient bit per cycle
// depends on sqw_pkg
module sqw_div import sqw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        busy,
  output logic        done,
  output logic [12:0] quo
);

  logic [20:0] q_r, q_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [8:0]  den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [9:0]  trial;

  // one shift and subtract step
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[20]};
    if (req.start && !busy_r) begin
      q_nxt    = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 5'd20;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 9'(trial - {1'b0, den_r});
        q_nxt   = {q_r[19:0], 1'b1};
      end else begin
        rem_nxt = trial[8:0];
        q_nxt   = {q_r[19:0], 1'b0};
      end
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r[12:0];

endmodule

// File: hw/rtl/square_wave_sound_generator_core.sv
// square wave sound generator: index/data bus port and sample mixer
// pitch writes wait on the bit-serial divider (an octave pair runs it for both voices);
// ticks read each voice and update its phase when its tone is enabled, then advance each
// noise generator; one item in flight at a time
// synchronous active-low reset clears control and marks both memories empty (reads as zero)
`include "square_wave_sound_generator_core_macros.svh"
module square_wave_sound_generator_core import sqw_pkg::*; #(
  parameter int CHIP_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_port_addr,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [13:0] out_left_sample,
  output logic [13:0] out_right_sample
);

  localparam int VOICES = 6 * CHIP_COUNT;
  localparam int NGEN   = 2 * CHIP_COUNT;
  localparam int RFD    = 32 * CHIP_COUNT;
  localparam int VW     = $clog2(VOICES);
  localparam int NW     = $clog2(NGEN);
  localparam int RW     = $clog2(RFD);
  localparam int CW     = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;

  state_t state_r, state_nxt;
  act_t   act_r, act_nxt;
  logic [1:0] port_r, port_nxt;
  logic [7:0] data_r, data_nxt;
  logic [4:0] idx_latch_r [CHIP_COUNT];
  logic [4:0] idx_latch_nxt [CHIP_COUNT];
  logic [5:0] tone_en_r [CHIP_COUNT];
  logic [5:0] tone_en_nxt [CHIP_COUNT];
  logic [5:0] noise_en_r [CHIP_COUNT];
  logic [5:0] noise_en_nxt [CHIP_COUNT];
  logic       glob_r [CHIP_COUNT];
  logic       glob_nxt [CHIP_COUNT];
  logic [1:0]  nmode_r [NGEN];
  logic [1:0]  nmode_nxt [NGEN];
  logic [15:0] nshift_r [NGEN];
  logic [15:0] nshift_nxt [NGEN];
  logic [14:0] nphase_r [NGEN];
  logic [14:0] nphase_nxt [NGEN];
  logic [12:0] nstep_r [NGEN];
  logic [12:0] nstep_nxt [NGEN];
  logic [VW-1:0] v_r, v_nxt;
  logic [VW-1:0] vaddr_r, vaddr_nxt;
  logic [CW-1:0] chip_r, chip_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [13:0]   lsum_r, lsum_nxt;
  logic [13:0]   rsum_r, rsum_nxt;
  logic [7:0]    rdat_r, rdat_nxt;
  logic          pair_r, pair_nxt;
  voice_t        vent_r, vent_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_rd_r, out_rd_nxt;
  logic [13:0]   out_l_r, out_l_nxt;
  logic [13:0]   out_r_r, out_r_nxt;

  // register file memory with per-entry valid bits
  logic [7:0]    regf_mem [RFD];
  logic          regf_vld [RFD];
  logic          rf_we;
  logic [RW-1:0] rf_waddr, rf_raddr;
  logic [7:0]    rf_q_r;
  logic          rf_qv_r;

  // voice state memory with per-entry valid bits
  voice_t        voice_mem [VOICES];
  logic          voice_vld [VOICES];
  logic          vm_we;
  logic [VW-1:0] vm_waddr, vm_raddr;
  voice_t        vm_wdata;
  voice_t        vm_q_r;
  logic          vm_qv_r;

  div_req_t    div_req;
  logic        div_busy, div_done;
  logic [12:0] div_quo;

  sqw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic          present;
  logic [CW-1:0] ci;
  logic [4:0]    cidx;
  voice_t        e;
  logic [15:0]   tph;
  logic [15:0]   rate;
  logic [15:0]   nph;
  logic [15:0]   nsh;
  logic [NW-1:0] gen;
  logic [NW-1:0] nidx;
  logic [15:0]   nshift_rd;
  logic          ena, nena;
  logic [13:0]   lmix, rmix;

  assign present   = int'(port_r[1]) < CHIP_COUNT;
  assign ci        = CW'(port_r[1]);
  assign cidx      = idx_latch_r[ci];
  assign rf_waddr  = RW'(int'(port_r[1]) * 32 + int'(cidx));
  assign rf_raddr  = rf_waddr;
  assign gen       = NW'(int'(chip_r) * 2 + int'(bit_r >= 3'd3));
  assign nidx      = (state_r == S_NOISE) ? n_r : gen;
  assign nshift_rd = nshift_r[nidx];
  assign lmix      = 14'({10'd0, e.vol[3:0]} * 14'(MIX_SCALE));
  assign rmix      = 14'({10'd0, e.vol[7:4]} * 14'(MIX_SCALE));
  assign e         = vm_qv_r ? vm_q_r : '0;
  assign in_stall  = (state_r != S_IDLE);

  // sequencer: next state, memory strobes and state updates
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    port_nxt      = port_r;
    data_nxt      = data_r;
    idx_latch_nxt = idx_latch_r;
    tone_en_nxt   = tone_en_r;
    noise_en_nxt  = noise_en_r;
    glob_nxt      = glob_r;
    nmode_nxt     = nmode_r;
    nshift_nxt    = nshift_r;
    nphase_nxt    = nphase_r;
    nstep_nxt     = nstep_r;
    v_nxt         = v_r;
    vaddr_nxt     = vaddr_r;
    chip_nxt      = chip_r;
    bit_nxt       = bit_r;
    n_nxt         = n_r;
    lsum_nxt      = lsum_r;
    rsum_nxt      = rsum_r;
    rdat_nxt      = rdat_r;
    pair_nxt      = pair_r;
    vent_nxt      = vent_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rd_nxt    = out_rd_r;
    out_l_nxt     = out_l_r;
    out_r_nxt     = out_r_r;
    rf_we         = 1'b0;
    vm_we         = 1'b0;
    vm_waddr      = vaddr_r;
    vm_wdata      = vent_r;
    vm_raddr      = v_r;
    div_req       = '0;
    tph           = '0;
    rate          = '0;
    nph           = '0;
    nsh           = '0;
    ena           = 1'b0;
    nena          = 1'b0;

    case (state_r)
      // take one beat
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = act_t'(in_action);
          port_nxt  = in_port_addr;
          data_nxt  = in_write_data;
          rdat_nxt  = '0;
          lsum_nxt  = '0;
          rsum_nxt  = '0;
          pair_nxt  = 1'b0;
          state_nxt = S_CMD;
        end
      end

      // decode the beat
      S_CMD: begin
        state_nxt = S_DONE;
        case (act_r)
          ACT_WRITE: begin
            if (present && port_r[0]) begin
              idx_latch_nxt[ci] = data_r[4:0];
            end else if (present) begin
              rf_we = 1'b1;
              if (cidx == REG_TONE_EN) tone_en_nxt[ci] = data_r[5:0];
              if (cidx == REG_NOISE_EN) noise_en_nxt[ci] = data_r[5:0];
              if (cidx == REG_GLOBAL) glob_nxt[ci] = data_r[0];
              if (cidx == REG_NOISE_MD) begin
                nmode_nxt[NW'(int'(ci) * 2)]     = data_r[1:0];
                nmode_nxt[NW'(int'(ci) * 2 + 1)] = data_r[5:4];
              end
              if (cidx <= REG_VOL_LAST ||
                  (cidx >= REG_NOTE_LO && cidx <= REG_NOTE_HI)) begin
                vaddr_nxt = VW'(int'(cidx[2:0]) + int'(ci) * 6);
                state_nxt = S_VRD;
              end else if (cidx >= REG_OCT_LO && cidx <= REG_OCT_HI) begin
                vaddr_nxt = VW'(int'(cidx[1:0]) * 2 + int'(ci) * 6);
                pair_nxt  = 1'b1;
                state_nxt = S_VRD;
              end
              vm_raddr = vaddr_nxt;
            end
          end
          ACT_READ: begin
            if (present && port_r[0]) begin
              rdat_nxt = {3'd0, cidx};
            end else if (present) begin
              state_nxt = S_RFRD;
            end
          end
          ACT_TICK: begin
            v_nxt     = '0;
            chip_nxt  = '0;
            bit_nxt   = '0;
            state_nxt = S_TRD;
          end
          default: state_nxt = S_DONE;
        endcase
      end

      // register file read data
      S_RFRD: begin
        rdat_nxt  = rf_qv_r ? rf_q_r : '0;
        state_nxt = S_DONE;
      end

      // voice entry arrived for a bus write
      S_VRD: begin
        vent_nxt = e;
        if (cidx <= REG_VOL_LAST) begin
          vent_nxt.vol = data_r;
          vm_we        = 1'b1;
          vm_wdata     = vent_nxt;
          state_nxt    = S_DONE;
        end else begin
          if (cidx <= REG_NOTE_HI) vent_nxt.pitch[7:0] = data_r;
          else if (pair_r) vent_nxt.pitch[10:8] = data_r[2:0];
          else vent_nxt.pitch[10:8] = data_r[6:4];
          div_req.start = 1'b1;
          div_req.num   = TONE_BASE << vent_nxt.pitch[10:8];
          div_req.den   = NOTE_BASE - {1'b0, vent_nxt.pitch[7:0]};
          state_nxt     = S_DIV;
        end
      end

      // wait for the step, then write back; second voice of an octave pair
      S_DIV: begin
        if (div_done) begin
          vm_we         = 1'b1;
          vm_wdata      = vent_r;
          vm_wdata.step = div_quo;
          if (pair_r) begin
            pair_nxt  = 1'b0;
            vaddr_nxt = vaddr_r + VW'(1);
            vm_raddr  = vaddr_nxt;
            state_nxt = S_VRD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      // tick: read voice
      S_TRD: begin
        vm_raddr  = v_r;
        state_nxt = S_TWR;
      end

      // tick: mix and advance one voice
      S_TWR: begin
        ena  = glob_r[chip_r] && tone_en_r[chip_r][bit_r];
        nena = glob_r[chip_r] && noise_en_r[chip_r][bit_r];
        vent_nxt = e;
        if (ena) begin
          if (e.level) begin
            lsum_nxt = lsum_r + lmix;
            rsum_nxt = rsum_r + rmix;
          end
          tph = {1'b0, e.phase} + {3'd0, e.step};
          if (tph >= PHASE_MOD) begin
            tph            = tph - PHASE_MOD;
            vent_nxt.level = !e.level;
          end
          vent_nxt.phase = tph[14:0];
          vm_we    = 1'b1;
          vm_waddr = v_r;
          vm_wdata = vent_nxt;
        end else if (nena && nshift_rd[0]) begin
          lsum_nxt = lsum_r + lmix;
          rsum_nxt = rsum_r + rmix;
        end
        if (bit_r == 3'd0 || bit_r == 3'd3) nstep_nxt[gen] = e.step;
        if (int'(v_r) == VOICES - 1) begin
          n_nxt     = '0;
          state_nxt = S_NOISE;
        end else begin
          v_nxt = v_r + VW'(1);
          if (bit_r == 3'd5) begin
            bit_nxt  = '0;
            chip_nxt = chip_r + CW'(1);
          end else begin
            bit_nxt = bit_r + 3'd1;
          end
          state_nxt = S_TRD;
        end
      end

      // tick: advance one noise generator, at most two shifts
      S_NOISE: begin
        case (nmode_r[n_r])
          2'd0:    rate = RATE_FAST;
          2'd1:    rate = RATE_MID;
          2'd2:    rate = RATE_SLOW;
          default: rate = {3'd0, nstep_r[n_r]};
        endcase
        nph = {1'b0, nphase_r[n_r]} + rate;
        nsh = nshift_rd;
        if (nph >= PHASE_MOD) begin
          nph = nph - PHASE_MOD;
          nsh = lfsr_step(nsh);
        end
        if (nph >= PHASE_MOD) begin
          nph = nph - PHASE_MOD;
          nsh = lfsr_step(nsh);
        end
        nshift_nxt[n_r] = nsh;
        nphase_nxt[n_r] = nph[14:0];
        if (int'(n_r) == NGEN - 1) state_nxt = S_DONE;
        else n_nxt = n_r + NW'(1);
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rdat_r;
          out_l_nxt     = lsum_r;
          out_r_nxt     = rsum_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    port_r   <= port_nxt;
    data_r   <= data_nxt;
    nstep_r  <= nstep_nxt;
    v_r      <= v_nxt;
    vaddr_r  <= vaddr_nxt;
    chip_r   <= chip_nxt;
    bit_r    <= bit_nxt;
    n_r      <= n_nxt;
    lsum_r   <= lsum_nxt;
    rsum_r   <= rsum_nxt;
    rdat_r   <= rdat_nxt;
    pair_r   <= pair_nxt;
    vent_r   <= vent_nxt;
    out_rd_r <= out_rd_nxt;
    out_l_r  <= out_l_nxt;
    out_r_r  <= out_r_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHIP_COUNT; i++) begin
        idx_latch_r[i] <= '0;
        tone_en_r[i]   <= '0;
        noise_en_r[i]  <= '0;
        glob_r[i]      <= 1'b0;
      end
      for (int i = 0; i < NGEN; i++) begin
        nmode_r[i]  <= '0;
        nshift_r[i] <= '0;
        nphase_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_latch_r <= idx_latch_nxt;
      tone_en_r   <= tone_en_nxt;
      noise_en_r  <= noise_en_nxt;
      glob_r      <= glob_nxt;
      nmode_r     <= nmode_nxt;
      nshift_r    <= nshift_nxt;
      nphase_r    <= nphase_nxt;
    end
  end

  // register file: one write, one registered read
  always_ff @(posedge clk) begin
    if (rf_we) regf_mem[rf_waddr] <= data_r;
    rf_q_r  <= regf_mem[rf_raddr];
    rf_qv_r <= regf_vld[rf_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RFD; i++) regf_vld[i] <= 1'b0;
    end else if (rf_we) begin
      regf_vld[rf_waddr] <= 1'b1;
    end
  end

  // voice memory: one write, one registered read; reading the entry being written gives its old value
  always_ff @(posedge clk) begin
    if (vm_we) voice_mem[vm_waddr] <= vm_wdata;
    vm_q_r  <= voice_mem[vm_raddr];
    vm_qv_r <= voice_vld[vm_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) voice_vld[i] <= 1'b0;
    end else if (vm_we) begin
      voice_vld[vm_waddr] <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_rd_r;
  assign out_left_sample  = out_l_r;
  assign out_right_sample = out_r_r;

  // checks
  `SQW_ASSERT_NXT(a_accept_cmd, in_valid && !in_stall, state_r == S_CMD,
    "accepted beat not decoded")
  `SQW_ASSERT_IMP(a_div_free, div_req.start, !div_busy, "divider started while busy")
  `SQW_ASSERT_IMP(a_tick_no_rdat,
    out_valid && (out_left_sample != 14'd0 || out_right_sample != 14'd0),
    out_read_data == 8'd0, "tick beat carries read data")
  `SQW_ASSERT_NXT(a_out_load, state_r == S_DONE && (!out_valid_r || !out_stall),
    out_valid_r && state_r == S_IDLE, "result not loaded")

endmodule

// File: tb/square_wave_sound_generator_core_test.sv
// testbench for the square wave sound generator core: bus writes, reads and sample ticks
// depends on sqw_pkg and the square_wave_sound_generator_core rtl
module square_wave_sound_generator_core_test import sqw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [1:0]  in_port_addr;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_data;
  logic [13:0] out_left_sample;
  logic [13:0] out_right_sample;

  square_wave_sound_generator_core #(.CHIP_COUNT(2)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_port_addr(in_port_addr), .in_write_data(in_write_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_read_data(out_read_data),
    .out_left_sample(out_left_sample), .out_right_sample(out_right_sample)
  );

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [7:0]  rd;
    logic [13:0] left;
    logic [13:0] right;
  } mix_beat_t;

  // predictor state
  logic [4:0]  idx_q[2];
  logic [7:0]  regs_q[64];
  logic [10:0] pitch_q[12];
  logic [12:0] step_q[12];
  logic [14:0] phase_q[12];
  logic        level_q[12];
  logic [7:0]  vol_q[12];
  logic [15:0] lfsr_q[4];
  logic [14:0] nphase_q[4];
  logic [1:0]  nmode_q[4];

  mix_beat_t expected_beats[$];
  int mismatches;
  int cycles;
  bit timed_out;

  // clock and cycle limit
  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void predict_reset();
    for (int i = 0; i < 64; i++) regs_q[i] = '0;
    for (int v = 0; v < 12; v++) begin
      pitch_q[v] = '0; step_q[v] = '0; phase_q[v] = '0; level_q[v] = 1'b0; vol_q[v] = '0;
    end
    for (int g = 0; g < 4; g++) begin
      lfsr_q[g] = '0; nphase_q[g] = '0; nmode_q[g] = '0;
    end
    idx_q[0] = '0; idx_q[1] = '0;
  endfunction

  function automatic void update_step(int v);
    logic [31:0] num;
    num = 32'd15625 << pitch_q[v][10:8];
    step_q[v] = 13'(num / (32'd511 - 32'(pitch_q[v][7:0])));
  endfunction

  // compute the expected beat of one accepted item, advancing predictor state
  function automatic mix_beat_t predict_mix(logic [1:0] act, logic [1:0] port, logic [7:0] d);
    mix_beat_t r;
    int chip, idx, v;
    logic [31:0] l, rr, ph, rate;
    logic [15:0] n;
    logic glob, ena, nena;
    r = '0;
    chip = port[1];
    l = 0; rr = 0;
    if (act == ACT_WRITE) begin
      if (port[0]) idx_q[chip] = d[4:0];
      else begin
        idx = idx_q[chip];
        regs_q[chip * 32 + idx] = d;
        if (idx <= 5) vol_q[idx + chip * 6] = d;
        else if (idx >= 8 && idx <= 13) begin
          v = (idx & 7) + chip * 6;
          pitch_q[v] = {pitch_q[v][10:8], d};
          update_step(v);
        end else if (idx >= 16 && idx <= 18) begin
          v = ((idx & 3) << 1) + chip * 6;
          pitch_q[v][10:8] = d[2:0];
          pitch_q[v + 1][10:8] = d[6:4];
          update_step(v);
          update_step(v + 1);
        end else if (idx == REG_NOISE_MD) begin
          nmode_q[chip * 2] = d[1:0];
          nmode_q[chip * 2 + 1] = d[5:4];
        end
      end
    end else if (act == ACT_READ) begin
      if (port[0]) r.rd = 8'(idx_q[chip]);
      else r.rd = regs_q[chip * 32 + idx_q[chip]];
    end else if (act == ACT_TICK) begin
      for (int dv = 0; dv < 12; dv++) begin
        glob = regs_q[(dv / 6) * 32 + REG_GLOBAL][0];
        ena = glob & regs_q[(dv / 6) * 32 + REG_TONE_EN][dv % 6];
        nena = glob & regs_q[(dv / 6) * 32 + REG_NOISE_EN][dv % 6];
        if (ena) begin
          if (level_q[dv]) begin
            l += vol_q[dv][3:0] * 90; rr += vol_q[dv][7:4] * 90;
          end
          ph = phase_q[dv] + step_q[dv];
          if (ph >= 22050) begin
            ph -= 22050; level_q[dv] = ~level_q[dv];
          end
          phase_q[dv] = ph[14:0];
        end else if (nena && lfsr_q[dv / 3][0]) begin
          l += vol_q[dv][3:0] * 90; rr += vol_q[dv][7:4] * 90;
        end
      end
      for (int g = 0; g < 4; g++) begin
        case (nmode_q[g])
          2'd0: rate = 31250;
          2'd1: rate = 15625;
          2'd2: rate = 7812;
          default: rate = step_q[g * 3];
        endcase
        ph = nphase_q[g] + rate;
        while (ph >= 22050) begin
          ph -= 22050;
          n = {lfsr_q[g][14:0], 1'b0};
          if (n[14] == n[6]) n[0] = 1'b1;
          lfsr_q[g] = n;
        end
        nphase_q[g] = ph[14:0];
      end
      r.left = l[13:0];
      r.right = rr[13:0];
    end
    return r;
  endfunction

  // receiver: stall pattern plus beat checking
  int stall_mode;
  always @(posedge clk) begin
    mix_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat rd=%0d l=%0d r=%0d",
          out_read_data, out_left_sample, out_right_sample);
      end else begin
        e = expected_beats.pop_front();
        if (out_read_data !== e.rd || out_left_sample !== e.left
            || out_right_sample !== e.right) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp rd=%0d l=%0d r=%0d got rd=%0d l=%0d r=%0d",
              e.rd, e.left, e.right, out_read_data, out_left_sample, out_right_sample);
        end
      end
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
  end

  // sender: one beat, with bursty gaps
  int burst_left;
  task automatic send_beat(logic [1:0] act, logic [1:0] port, logic [7:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_port_addr <= port;
    in_write_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_beats.push_back(predict_mix(act, port, d));
  endtask

  task automatic reg_write(int chip, logic [4:0] idx, logic [7:0] d);
    send_beat(ACT_WRITE, {1'(chip), 1'b1}, 8'(idx));
    send_beat(ACT_WRITE, {1'(chip), 1'b0}, d);
  endtask

  // directed: extremes, every action, unused code, noise and tone paths
  task automatic test_directed();
    send_beat(ACT_TICK, 2'd0, 8'h00);
    send_beat(ACT_READ, 2'd1, 8'h00);
    send_beat(2'd3, 2'd3, 8'hFF);
    reg_write(0, 5'h00, 8'hFF);
    reg_write(1, 5'h05, 8'hFF);
    reg_write(0, 5'h08, 8'hFF);
    reg_write(0, 5'h10, 8'hFF);
    reg_write(1, REG_NOISE_MD, 8'h33);
    reg_write(0, REG_TONE_EN, 8'h01);
    reg_write(0, REG_NOISE_EN, 8'h3F);
    reg_write(0, REG_GLOBAL, 8'h01);
    reg_write(1, REG_GLOBAL, 8'h01);
    send_beat(ACT_READ, 2'd2, 8'h00);
    send_beat(ACT_READ, 2'd3, 8'h00);
    repeat (4) send_beat(ACT_TICK, 2'd1, 8'h00);
  endtask

  // random: mostly register setup plus ticks; some noise beats
  task automatic test_random(int count);
    int n, k;
    n = 0;
    while (n < count) begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        reg_write($urandom_range(0, 1), 5'($urandom_range(0, 31)), 8'($urandom));
        n += 2;
      end else if (k < 5) begin
        reg_write($urandom_range(0, 1), 5'($urandom_range(20, 22)), 8'($urandom));
        n += 2;
      end else if (k < 8) begin
        send_beat(ACT_TICK, 2'($urandom), 8'($urandom));
        n++;
      end else begin
        send_beat(2'($urandom), 2'($urandom), 8'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = '0;
    in_port_addr = '0;
    in_write_data = '0;
    out_stall = 1'b0;
    mismatches = 0;
    cycles = 0;
    timed_out = 1'b0;
    stall_mode = 0;
    burst_left = 0;
    predict_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1800);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
